// ===== rtl/hbrp_pkg.sv =====
// shared types, character codes and prefix table for the byte range parser
package hbrp_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_A_LEAD = 3'd1,
        PH_A_SIGN = 3'd2,
        PH_A_DIG  = 3'd3,
        PH_DASH   = 3'd4,
        PH_B_LEAD = 3'd5,
        PH_B_SIGN = 3'd6,
        PH_B_DIG  = 3'd7
    } phase_t;

    localparam int unsigned NUM_BITS   = 64;
    localparam int unsigned PREFIX_LEN = 6;

    localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_LEN - 1);

    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // characters of "bytes="
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3d;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

// ===== rtl/http_byte_range_parser.sv =====
// single byte range parser for an http range header value
//
// the request channel (byte_valid / byte_stall) carries one header byte per
// request with the resource size and a flag on the final byte. the result
// channel (range_valid / range_stall) carries one result per header value,
// sent for the request flagged last_byte: range_ok, range_start and
// range_len (zero when not ok).
// a request enters an input register and is parsed there against the running
// state, and a final byte moves to a check stage whose answer is registered
// in the output register.
// one request is taken every cycle while byte_stall is low; the per-byte
// multiply-by-ten-add on the 64-bit accumulator sets the cycle time.
// each stage holds its contents while the stage after it is full and stalled,
// so bytes that cause no result keep flowing while a result waits; byte_stall
// rises only when every stage up to the output register is blocked.
// reset empties all stages and returns the parser to the start of a value;
// after each final byte the parser also returns there by itself.
module http_byte_range_parser #(
    parameter int unsigned SIZE_BITS = 27
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  logic [7:0]             value_byte,
    input  logic [SIZE_BITS-1:0]   total_size,
    input  logic                   last_byte,
    output logic                   range_valid,
    input  logic                   range_stall,
    output logic                   range_ok,
    output logic [SIZE_BITS-2:0]   range_start,
    output logic [SIZE_BITS-1:0]   range_len
);

    localparam int unsigned NB = hbrp_pkg::NUM_BITS;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(1) << (SIZE_BITS - 1);

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic [SIZE_BITS-1:0] in_size_reg;
    logic                 in_last_reg;

    // parser state
    hbrp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       pos_reg, pos_next;
    logic [NB-1:0]    acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic             neg_reg, neg_next;
    logic [NB-1:0]    first_reg, first_next;
    logic             rej_reg, rej_next;

    // check stage
    logic                 chk_valid_reg, chk_valid_next;
    logic                 chk_pre_reg;
    logic                 chk_dash_reg;
    logic                 chk_neg_reg;
    logic [NB-1:0]        chk_first_reg;
    logic [NB-1:0]        chk_acc_reg;
    logic [SIZE_BITS-1:0] chk_total_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg;
    logic [SIZE_BITS-2:0] out_start_reg;
    logic [SIZE_BITS-1:0] out_len_reg;

    logic ready_out, ready_chk, ready_in, consume, chk_adv;

    // parsed values after the current byte
    hbrp_pkg::phase_t phase_f;
    logic [2:0]       pos_f;
    logic [NB-1:0]    acc_f;
    logic             ovf_f;
    logic             neg_f;
    logic [NB-1:0]    first_f;
    logic             rej_f;

    logic [NB+3:0]        acc_x10;
    logic                 add_ovf;
    logic [7:0]           c;
    logic                 c_space, c_digit, c_sign;
    logic [SIZE_BITS-1:0] total_clamp;

    logic [NB-1:0]        total_ext, last_val, len_full;
    logic                 chk_ok;

    // handshake
    assign ready_out  = !out_valid_reg || !range_stall;
    assign chk_adv    = chk_valid_reg && ready_out;
    assign ready_chk  = !chk_valid_reg || ready_out;
    assign consume    = in_valid_reg && (!in_last_reg || ready_chk);
    assign ready_in   = !in_valid_reg || consume;
    assign byte_stall = !ready_in;

    assign c       = in_byte_reg;
    assign c_space = hbrp_pkg::is_space(c);
    assign c_digit = hbrp_pkg::is_digit(c);
    assign c_sign  = (c == hbrp_pkg::CHAR_PLUS) || (c == hbrp_pkg::CHAR_MINUS);

    // acc * 10 + digit, overflow when it leaves 64 bits
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {{(NB-4){1'b0}}, (c - hbrp_pkg::CHAR_ZERO)};
    assign add_ovf = |acc_x10[NB+3:NB];

    // byte parser
    always_comb
    begin
        phase_f = phase_reg;
        pos_f   = pos_reg;
        acc_f   = acc_reg;
        ovf_f   = ovf_reg;
        neg_f   = neg_reg;
        first_f = first_reg;
        rej_f   = rej_reg;
        if (!rej_reg)
        begin
            if (c == hbrp_pkg::CHAR_COMMA)
            begin
                rej_f = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    hbrp_pkg::PH_PREFIX:
                    begin
                        if (c == hbrp_pkg::prefix_char(pos_reg))
                        begin
                            pos_f = pos_reg + 3'd1;
                            if (pos_reg == hbrp_pkg::PREFIX_LAST)
                                phase_f = hbrp_pkg::PH_A_LEAD;
                        end
                        else
                            rej_f = 1'b1;
                    end
                    hbrp_pkg::PH_A_LEAD, hbrp_pkg::PH_DASH, hbrp_pkg::PH_B_LEAD:
                    begin
                        if (c_space)
                        begin
                            phase_f = (phase_reg == hbrp_pkg::PH_A_LEAD) ?
                                      hbrp_pkg::PH_A_LEAD : hbrp_pkg::PH_B_LEAD;
                        end
                        else if (c_sign)
                        begin
                            neg_f   = (c == hbrp_pkg::CHAR_MINUS);
                            phase_f = (phase_reg == hbrp_pkg::PH_A_LEAD) ?
                                      hbrp_pkg::PH_A_SIGN : hbrp_pkg::PH_B_SIGN;
                        end
                        else if (c_digit)
                        begin
                            if (!ovf_reg)
                            begin
                                if (add_ovf)
                                    ovf_f = 1'b1;
                                else
                                    acc_f = acc_x10[NB-1:0];
                            end
                            phase_f = (phase_reg == hbrp_pkg::PH_A_LEAD) ?
                                      hbrp_pkg::PH_A_DIG : hbrp_pkg::PH_B_DIG;
                        end
                        else
                            rej_f = 1'b1;
                    end
                    hbrp_pkg::PH_A_SIGN, hbrp_pkg::PH_B_SIGN:
                    begin
                        if (c_digit)
                        begin
                            if (!ovf_reg)
                            begin
                                if (add_ovf)
                                    ovf_f = 1'b1;
                                else
                                    acc_f = acc_x10[NB-1:0];
                            end
                            phase_f = (phase_reg == hbrp_pkg::PH_A_SIGN) ?
                                      hbrp_pkg::PH_A_DIG : hbrp_pkg::PH_B_DIG;
                        end
                        else
                            rej_f = 1'b1;
                    end
                    hbrp_pkg::PH_A_DIG:
                    begin
                        if (c_digit)
                        begin
                            if (!ovf_reg)
                            begin
                                if (add_ovf)
                                    ovf_f = 1'b1;
                                else
                                    acc_f = acc_x10[NB-1:0];
                            end
                        end
                        else if ((c == hbrp_pkg::CHAR_MINUS) && !ovf_reg)
                        begin
                            first_f = neg_reg ? (NB'(0) - acc_reg) : acc_reg;
                            acc_f   = '0;
                            ovf_f   = 1'b0;
                            neg_f   = 1'b0;
                            phase_f = hbrp_pkg::PH_DASH;
                        end
                        else
                            rej_f = 1'b1;
                    end
                    hbrp_pkg::PH_B_DIG:
                    begin
                        if (c_digit)
                        begin
                            if (!ovf_reg)
                            begin
                                if (add_ovf)
                                    ovf_f = 1'b1;
                                else
                                    acc_f = acc_x10[NB-1:0];
                            end
                        end
                        else
                            rej_f = 1'b1;
                    end
                    default:
                        rej_f = 1'b1;
                endcase
            end
        end
    end

    // state and stage valid next values
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        rej_next   = rej_reg;
        if (consume)
        begin
            if (in_last_reg)
            begin
                phase_next = hbrp_pkg::PH_PREFIX;
                pos_next   = '0;
                acc_next   = '0;
                ovf_next   = 1'b0;
                neg_next   = 1'b0;
                first_next = '0;
                rej_next   = 1'b0;
            end
            else
            begin
                phase_next = phase_f;
                pos_next   = pos_f;
                acc_next   = acc_f;
                ovf_next   = ovf_f;
                neg_next   = neg_f;
                first_next = first_f;
                rej_next   = rej_f;
            end
        end

        in_valid_next = in_valid_reg;
        if (ready_in)
            in_valid_next = byte_valid;

        chk_valid_next = chk_valid_reg;
        if (consume && in_last_reg)
            chk_valid_next = 1'b1;
        else if (chk_adv)
            chk_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (ready_out)
            out_valid_next = chk_valid_reg;
    end

    // size clamp
    assign total_clamp = (in_size_reg > SIZE_MAX) ? SIZE_MAX : in_size_reg;

    // range check
    assign total_ext = {{(NB-SIZE_BITS){1'b0}}, chk_total_reg};
    always_comb
    begin
        if (chk_dash_reg)
            last_val = (chk_total_reg == '0) ? '0 : (total_ext - NB'(1));
        else
            last_val = chk_neg_reg ? (NB'(0) - chk_acc_reg) : chk_acc_reg;
    end
    assign chk_ok   = chk_pre_reg && (chk_first_reg < total_ext)
                    && (last_val >= chk_first_reg) && (last_val < total_ext);
    assign len_full = last_val - chk_first_reg + NB'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= hbrp_pkg::PH_PREFIX;
            pos_reg       <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            first_reg     <= '0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            rej_reg       <= rej_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && ready_in)
        begin
            in_byte_reg <= value_byte;
            in_size_reg <= total_size;
            in_last_reg <= last_byte;
        end
        if (consume && in_last_reg)
        begin
            chk_pre_reg   <= !rej_f && !ovf_f &&
                             ((phase_f == hbrp_pkg::PH_DASH) || (phase_f == hbrp_pkg::PH_B_DIG));
            chk_dash_reg  <= (phase_f == hbrp_pkg::PH_DASH);
            chk_neg_reg   <= neg_f;
            chk_first_reg <= first_f;
            chk_acc_reg   <= acc_f;
            chk_total_reg <= total_clamp;
        end
        if (chk_adv)
        begin
            out_ok_reg    <= chk_ok;
            out_start_reg <= chk_ok ? chk_first_reg[SIZE_BITS-2:0] : '0;
            out_len_reg   <= chk_ok ? len_full[SIZE_BITS-1:0] : '0;
        end
    end

    assign range_valid = out_valid_reg;
    assign range_ok    = out_ok_reg;
    assign range_start = out_start_reg;
    assign range_len   = out_len_reg;

endmodule

// ===== rtl/hbrp_checker.sv =====
// port-level checks for the byte range parser and their bind
module hbrp_checker #(
    parameter int unsigned SIZE_BITS = 27
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 range_valid,
    input logic                 range_stall,
    input logic                 range_ok,
    input logic [SIZE_BITS-2:0] range_start,
    input logic [SIZE_BITS-1:0] range_len
);

    localparam logic [SIZE_BITS:0] SPAN_MAX = (SIZE_BITS+1)'(1) << (SIZE_BITS - 1);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        range_valid && range_stall |=>
            range_valid && $stable(range_ok) && $stable(range_start) && $stable(range_len))
    else $error("stalled result changed");

    // rejected request reports zero start and length
    assert property (@(posedge clk) disable iff (!rst_n)
        range_valid && !range_ok |-> (range_start == '0) && (range_len == '0))
    else $error("rejected range carries nonzero fields");

    // an accepted range is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        range_valid && range_ok |-> (range_len != '0))
    else $error("accepted range has zero length");

    // an accepted range ends inside the largest resource
    assert property (@(posedge clk) disable iff (!rst_n)
        range_valid && range_ok |->
            ({2'b00, range_start} + {1'b0, range_len}) <= SPAN_MAX)
    else $error("accepted range runs past the size limit");

endmodule

bind http_byte_range_parser hbrp_checker #(
    .SIZE_BITS (SIZE_BITS)
) u_hbrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .range_valid (range_valid),
    .range_stall (range_stall),
    .range_ok    (range_ok),
    .range_start (range_start),
    .range_len   (range_len)
);

// ===== verif/http_byte_range_parser_tb.sv =====
// testbench for the http byte range parser: header stimulus, prediction and result checks
`timescale 1ns / 100ps

module http_byte_range_parser_tb;

    localparam int unsigned SIZE_BITS   = 27;
    localparam logic [63:0] SIZE_CAP    = 64'd1 << (SIZE_BITS - 1);
    localparam int          STUCK_LIMIT = 200;
    localparam int          TAIL_CYCLES = 12;

    typedef struct packed {
        logic [7:0]           data;
        logic [SIZE_BITS-1:0] total;
        logic                 tail;
    } hdr_byte_t;

    typedef struct packed {
        logic                 ok;
        logic [SIZE_BITS-2:0] start;
        logic [SIZE_BITS-1:0] length;
    } range_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 byte_valid   = 1'b0;
    logic [7:0]           value_byte   = '0;
    logic [SIZE_BITS-1:0] total_size   = '0;
    logic                 last_byte    = 1'b0;
    logic                 range_stall  = 1'b0;
    logic                 byte_stall;
    logic                 range_valid;
    logic                 range_ok;
    logic [SIZE_BITS-2:0] range_start;
    logic [SIZE_BITS-1:0] range_len;

    hdr_byte_t req_q[$];
    range_t    range_q[$];

    logic byte_taken   = 1'b0;
    bit   quiet        = 1'b0;
    int   tx_gap       = 0;
    int   rx_gap       = 0;
    int   queued_cnt   = 0;
    int   accepted_cnt = 0;
    int   results_seen = 0;
    int   ok_seen      = 0;
    int   errors       = 0;
    int   stuck_cycles = 0;

    // parser state mirrored by the testbench
    string            prefix_text = "bytes=";
    hbrp_pkg::phase_t ph          = hbrp_pkg::PH_PREFIX;
    logic [2:0]       pfx_idx     = '0;
    logic [63:0]      num_acc     = '0;
    logic [63:0]      first_num   = '0;
    logic             num_ovf     = 1'b0;
    logic             num_neg     = 1'b0;
    logic             bad_value   = 1'b0;

    http_byte_range_parser #(
        .SIZE_BITS(SIZE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .value_byte(value_byte),
        .total_size(total_size),
        .last_byte(last_byte),
        .range_valid(range_valid),
        .range_stall(range_stall),
        .range_ok(range_ok),
        .range_start(range_start),
        .range_len(range_len)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic blank_char(input logic [7:0] c);
        return (c == hbrp_pkg::CHAR_SPACE) ||
               (c >= hbrp_pkg::CHAR_TAB && c <= hbrp_pkg::CHAR_CR);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= hbrp_pkg::CHAR_ZERO && c <= hbrp_pkg::CHAR_NINE;
    endfunction

    function automatic logic [63:0] number_now();
        return num_neg ? (64'd0 - num_acc) : num_acc;
    endfunction

    task automatic clear_number();
        num_acc = '0;
        num_ovf = 1'b0;
        num_neg = 1'b0;
    endtask

    task automatic restart_parser();
        clear_number();
        ph        = hbrp_pkg::PH_PREFIX;
        pfx_idx   = '0;
        first_num = '0;
        bad_value = 1'b0;
    endtask

    task automatic accum_digit(input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, (c - hbrp_pkg::CHAR_ZERO)};
        if (!num_ovf)
        begin
            if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                num_ovf = 1'b1;
            else
                num_acc = num_acc * 64'd10 + d;
        end
    endtask

    task automatic number_lead(input logic [7:0] c, input hbrp_pkg::phase_t ws_ph,
                               input hbrp_pkg::phase_t sign_ph,
                               input hbrp_pkg::phase_t dig_ph);
        if (blank_char(c))
            ph = ws_ph;
        else if (c == hbrp_pkg::CHAR_PLUS || c == hbrp_pkg::CHAR_MINUS)
        begin
            num_neg = (c == hbrp_pkg::CHAR_MINUS);
            ph = sign_ph;
        end
        else if (digit_char(c))
        begin
            accum_digit(c);
            ph = dig_ph;
        end
        else
            bad_value = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        if (!bad_value)
        begin
            if (c == hbrp_pkg::CHAR_COMMA)
                bad_value = 1'b1;
            else
            begin
                case (ph)
                    hbrp_pkg::PH_PREFIX:
                    begin
                        if (c == prefix_text[pfx_idx])
                        begin
                            if (pfx_idx == hbrp_pkg::PREFIX_LAST)
                                ph = hbrp_pkg::PH_A_LEAD;
                            pfx_idx = pfx_idx + 3'd1;
                        end
                        else
                            bad_value = 1'b1;
                    end
                    hbrp_pkg::PH_A_LEAD:
                        number_lead(c, hbrp_pkg::PH_A_LEAD, hbrp_pkg::PH_A_SIGN,
                                    hbrp_pkg::PH_A_DIG);
                    hbrp_pkg::PH_DASH, hbrp_pkg::PH_B_LEAD:
                        number_lead(c, hbrp_pkg::PH_B_LEAD, hbrp_pkg::PH_B_SIGN,
                                    hbrp_pkg::PH_B_DIG);
                    hbrp_pkg::PH_A_SIGN, hbrp_pkg::PH_B_SIGN:
                    begin
                        if (!digit_char(c))
                            bad_value = 1'b1;
                        else
                        begin
                            accum_digit(c);
                            if (ph == hbrp_pkg::PH_A_SIGN)
                                ph = hbrp_pkg::PH_A_DIG;
                            else
                                ph = hbrp_pkg::PH_B_DIG;
                        end
                    end
                    hbrp_pkg::PH_A_DIG:
                    begin
                        if (digit_char(c))
                            accum_digit(c);
                        else if (c == hbrp_pkg::CHAR_MINUS && !num_ovf)
                        begin
                            first_num = number_now();
                            clear_number();
                            ph = hbrp_pkg::PH_DASH;
                        end
                        else
                            bad_value = 1'b1;
                    end
                    hbrp_pkg::PH_B_DIG:
                    begin
                        if (digit_char(c))
                            accum_digit(c);
                        else
                            bad_value = 1'b1;
                    end
                    default:
                        bad_value = 1'b1;
                endcase
            end
        end
    endtask

    // advance the mirrored parser by one request, queue a range on the final byte
    task automatic take_request(input logic [7:0] c, input logic [SIZE_BITS-1:0] sz,
                                input logic tail);
        logic [63:0] tot;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        logic        ok;
        range_t      want;
        parse_byte(c);
        if (tail)
        begin
            tot = 64'(sz);
            if (tot > SIZE_CAP)
                tot = SIZE_CAP;
            ok = !bad_value && !num_ovf &&
                 (ph == hbrp_pkg::PH_DASH || ph == hbrp_pkg::PH_B_DIG);
            lo = first_num;
            if (ph == hbrp_pkg::PH_DASH)
                hi = (tot == 64'd0) ? 64'd0 : tot - 64'd1;
            else
                hi = number_now();
            if (lo >= tot || hi < lo || hi >= tot)
                ok = 1'b0;
            span = hi - lo + 64'd1;
            want.ok     = ok;
            want.start  = ok ? lo[SIZE_BITS-2:0] : '0;
            want.length = ok ? span[SIZE_BITS-1:0] : '0;
            range_q.push_back(want);
            restart_parser();
        end
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin : drive_req
        hdr_byte_t nxt;
        if (rst_n && (!byte_valid || byte_taken))
        begin
            if (tx_gap > 0)
            begin
                byte_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (req_q.size() > 0)
            begin
                nxt = req_q.pop_front();
                value_byte <= nxt.data;
                total_size <= nxt.total;
                last_byte  <= nxt.tail;
                byte_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    tx_gap <= $urandom_range(1, 6);
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // result stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_gap > 0)
            begin
                range_stall <= 1'b1;
                rx_gap <= rx_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                range_stall <= 1'b1;
                rx_gap <= $urandom_range(0, 5);
            end
            else
                range_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch_ports
        range_t want;
        if (rst_n)
        begin
            byte_taken <= byte_valid && !byte_stall;
            if (byte_valid && !byte_stall)
            begin
                take_request(value_byte, total_size, last_byte);
                accepted_cnt++;
            end
            if (range_valid && !range_stall)
            begin
                results_seen++;
                if (range_ok === 1'b1)
                    ok_seen++;
                if (range_q.size() == 0)
                begin
                    $display("%0t: unexpected range, expected none actual ok=%0d start=%0d len=%0d",
                             $time, range_ok, range_start, range_len);
                    errors++;
                end
                else
                begin
                    want = range_q.pop_front();
                    cmp_field("range_ok", 64'(want.ok), 64'(range_ok));
                    cmp_field("range_start", 64'(want.start), 64'(range_start));
                    cmp_field("range_len", 64'(want.length), 64'(range_len));
                end
            end
            if ((byte_valid && !byte_stall) || (range_valid && !range_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("%0t: no request or range accepted for %0d cycles", $time, STUCK_LIMIT);
        $display("http_byte_range_parser_tb NOT OK");
        $finish;
    end

    task automatic add_req(input logic [7:0] c, input logic [SIZE_BITS-1:0] sz,
                           input logic tail);
        hdr_byte_t r;
        r.data  = c;
        r.total = sz;
        r.tail  = tail;
        req_q.push_back(r);
        queued_cnt++;
    endtask

    task automatic send_text(input string s, input logic [SIZE_BITS-1:0] sz,
                             input int bad_pos = -1, input logic [7:0] bad_val = 8'h00);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = (i == bad_pos) ? bad_val : s[i];
            add_req(c, sz, i == s.len() - 1);
        end
    endtask

    function automatic string lead_text();
        string       s;
        logic [7:0]  c;
        int          n;
        s = "";
        if ($urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n)
            begin
                c = ($urandom_range(0, 5) == 0) ? hbrp_pkg::CHAR_SPACE :
                    8'(hbrp_pkg::CHAR_TAB + $urandom_range(0, 4));
                s = {s, $sformatf("%c", c)};
            end
        end
        return s;
    endfunction

    function automatic string sign_text();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return "+";
        else if (r == 1)
            return "-";
        return "";
    endfunction

    function automatic string num_text(input logic [63:0] v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return "18446744073709551616";
        else if (r < 7)
            return $sformatf("%0d", 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3));
        else if (r < 10)
            return {"99999999999", $sformatf("%0d", v)};
        else if (r < 16)
            return {"00", $sformatf("%0d", v)};
        return $sformatf("%0d", v);
    endfunction

    // mostly well-formed ranges, some truncated, corrupted or pure noise
    task automatic rand_value();
        logic [SIZE_BITS-1:0] sz;
        logic [63:0]          cap;
        logic [63:0]          lo;
        logic [63:0]          hi;
        string                s;
        int                   kind;
        int                   n;
        n = $urandom_range(0, 99);
        if (n < 6)
            sz = '0;
        else if (n < 70)
            sz = SIZE_BITS'($urandom_range(1, 300));
        else if (n < 88)
            sz = SIZE_BITS'($urandom_range(301, (1 << 26) - 1));
        else if (n < 94)
            sz = SIZE_CAP[SIZE_BITS-1:0];
        else
            sz = SIZE_BITS'($urandom_range((1 << 26) + 1, (1 << 27) - 1));
        cap = (64'(sz) > SIZE_CAP) ? SIZE_CAP : 64'(sz);
        lo = 64'($urandom_range(0, 32'(cap + 64'd1)));
        if ($urandom_range(0, 1) == 0)
            hi = lo + 64'($urandom_range(0, 20));
        else
            hi = 64'($urandom_range(0, 32'(cap + 64'd1)));
        s = {"bytes=", lead_text(), sign_text(), num_text(lo), "-"};
        if ($urandom_range(0, 3) != 0)
            s = {s, lead_text(), sign_text(), num_text(hi)};
        kind = $urandom_range(0, 99);
        if (kind < 72)
            send_text(s, sz);
        else if (kind < 80)
            send_text(s.substr(0, $urandom_range(0, s.len() - 2)), sz);
        else if (kind < 86)
            send_text(s, sz, $urandom_range(0, s.len() - 1), hbrp_pkg::CHAR_COMMA);
        else if (kind < 93)
            send_text(s, sz, $urandom_range(0, s.len() - 1), 8'($urandom_range(0, 255)));
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                add_req(8'($urandom_range(0, 255)), sz, i == n - 1);
        end
    endtask

    task automatic drain();
        while (!(accepted_cnt == queued_cnt && range_q.size() == 0))
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int base;
        send_text("bytes=0-99", 1000);
        send_text("bytes=0-", 0);
        send_text("bytes=5-", 6);
        send_text({"bytes= \011\012+3-\013\014\015", "7"}, 10);
        send_text("bytes=-5-", 100);
        send_text("bytes=+0-+0", 1);
        send_text("bytes=007-0009", 20);
        send_text("bytes=3--0", 20);
        send_text("bytes=0-", 27'h7FF_FFFF);
        send_text("bytes=67108863-", SIZE_CAP[SIZE_BITS-1:0]);
        send_text("bytes=1-2,3-4", 100);
        send_text(",", 5);
        send_text("byte", 100);
        send_text("bytes=", 100);
        send_text("bytes=12", 100);
        send_text("bytes=1-+", 100);
        send_text("bytes=1- ", 100);
        send_text("bytes=1-5x", 100);
        send_text("bytes=--1", 100);
        send_text("bytes=1-2-3", 100);
        send_text("bytes=18446744073709551615-", 100);
        send_text("bytes=18446744073709551616-", 100);
        send_text("bytes=0-99999999999999999999", 100);
        send_text("Bytes=0-1", 100);
        send_text("bytes=0-1", 100, 0, 8'h00);
        send_text("bytes=0-1", 100, 8, 8'hFF);
        drain();

        base = queued_cnt;
        while (queued_cnt < base + 50)
            rand_value();
        drain();
        while (queued_cnt < base + 80)
            rand_value();
        drain();
        quiet = 1'b1;
        while (queued_cnt < base + 100)
            rand_value();
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        errors += range_q.size();

        $display("checked %0d ranges (%0d satisfiable) from %0d header bytes", results_seen,
                 ok_seen, accepted_cnt);
        $display("prefix, whitespace, sign, comma, overflow and size clamp cases under stalls");
        if (errors == 0)
            $display("http_byte_range_parser_tb OK");
        else
            $display("http_byte_range_parser_tb NOT OK");
        $finish;
    end

endmodule
